>>> rtl/core/tcc_pkg.sv
// Shared types and constants for the thermocouple code to temperature converter.
// Holds the segment breakpoint tables and the front-to-back item struct.
// No dependencies.
package tcc_pkg;

  localparam int SEG_COUNT = 21;
  localparam int SEG_W     = $clog2(SEG_COUNT);

  localparam int CODE_W  = 16;
  localparam int TEMP_W  = 14;
  localparam int DELTA_W = 8;   // code - breakpoint, at most 218
  localparam int SLOPE_W = 9;   // 10 * degrees across a segment, at most 400
  localparam int SPAN_W  = 8;   // codes across a segment
  localparam int X_W     = DELTA_W + SLOPE_W;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W = 20;
  localparam int QUOT_W  = 9;   // quotient at most 400

  localparam logic [RECIP_SHIFT:0] RecipOne = (RECIP_SHIFT+1)'(1) << RECIP_SHIFT;

  // lower breakpoint, exclusive (inclusive for the 0 to 5 C segment)
  localparam logic signed [CODE_W-1:0] SEG_LO [SEG_COUNT] = '{
    -16'sd148, -16'sd75, 16'sh0000, 16'sh0019, 16'sh0033, 16'sh0066, 16'sh009A,
    16'sh00CE, 16'sh0103, 16'sh0138, 16'sh01A2, 16'sh020C, 16'sh02DE, 16'sh03AC,
    16'sh0478, 16'sh0548, 16'sh061B, 16'sh06F2, 16'sh07C7, 16'sh089F, 16'sh0978
  };

  // upper breakpoint, inclusive
  localparam logic signed [CODE_W-1:0] SEG_HI [SEG_COUNT] = '{
    -16'sd75, 16'sd0, 16'sd25, 16'sd51, 16'sd102, 16'sd154, 16'sd206,
    16'sd259, 16'sd312, 16'sd418, 16'sd524, 16'sd734, 16'sd940, 16'sd1144,
    16'sd1352, 16'sd1563, 16'sd1778, 16'sd1991, 16'sd2207, 16'sd2424, 16'sd2642
  };

  localparam logic [SPAN_W-1:0] SEG_SPAN [SEG_COUNT] = '{
    8'd73, 8'd75, 8'd25, 8'd26, 8'd51, 8'd52, 8'd52, 8'd53, 8'd53, 8'd106, 8'd106,
    8'd210, 8'd206, 8'd204, 8'd208, 8'd211, 8'd215, 8'd213, 8'd216, 8'd217, 8'd218
  };

  localparam logic signed [TEMP_W-1:0] SEG_BASE [SEG_COUNT] = '{
    -14'sd300, -14'sd150, 14'sd0, 14'sd50, 14'sd100, 14'sd200, 14'sd300,
    14'sd400, 14'sd500, 14'sd600, 14'sd800, 14'sd1000, 14'sd1400, 14'sd1800,
    14'sd2200, 14'sd2600, 14'sd3000, 14'sd3400, 14'sd3800, 14'sd4200, 14'sd4600
  };

  localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_COUNT] = '{
    9'd150, 9'd150, 9'd50, 9'd50, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100,
    9'd200, 9'd200, 9'd400, 9'd400, 9'd400, 9'd400, 9'd400, 9'd400, 9'd400,
    9'd400, 9'd400, 9'd400
  };

  // floor(2^24 / span)
  localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_COUNT] = '{
    RECIP_W'(RecipOne / 73),  RECIP_W'(RecipOne / 75),  RECIP_W'(RecipOne / 25),
    RECIP_W'(RecipOne / 26),  RECIP_W'(RecipOne / 51),  RECIP_W'(RecipOne / 52),
    RECIP_W'(RecipOne / 52),  RECIP_W'(RecipOne / 53),  RECIP_W'(RecipOne / 53),
    RECIP_W'(RecipOne / 106), RECIP_W'(RecipOne / 106), RECIP_W'(RecipOne / 210),
    RECIP_W'(RecipOne / 206), RECIP_W'(RecipOne / 204), RECIP_W'(RecipOne / 208),
    RECIP_W'(RecipOne / 211), RECIP_W'(RecipOne / 215), RECIP_W'(RecipOne / 213),
    RECIP_W'(RecipOne / 216), RECIP_W'(RecipOne / 217), RECIP_W'(RecipOne / 218)
  };

  typedef struct packed {
    logic               inr;
    logic [SEG_W-1:0]   seg;
    logic [DELTA_W-1:0] delta;
  } item_t;

endpackage

>>> rtl/core/tcc_front.sv
// Front end: takes ADC codes, finds the segment and the offset into it.
// Uses tcc_pkg breakpoint tables; feeds tcc_queue.
module tcc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tcc_pkg::CODE_W-1:0] adc_code,
  output logic                              push,
  output tcc_pkg::item_t                    push_item,
  input  logic                              queue_full
);

  logic                          f_valid;
  tcc_pkg::item_t                f_item;
  tcc_pkg::item_t                item_next;
  logic                          found;
  logic [tcc_pkg::SEG_W-1:0]     seg_sel;
  logic signed [tcc_pkg::CODE_W-1:0] diff;
  logic                          hit;
  logic                          load;

  assign push     = f_valid && !queue_full;
  assign in_stall = f_valid && queue_full;
  assign load     = in_valid && !in_stall;
  assign push_item = f_item;

  // first matching segment wins; code 0 lands in the -15 to 0 C segment
  always_comb begin
    found   = 1'b0;
    seg_sel = '0;
    hit     = 1'b0;
    for (int i = 0; i < tcc_pkg::SEG_COUNT; i++) begin
      if (i == 2)
        hit = (adc_code >= tcc_pkg::SEG_LO[i]) && (adc_code <= tcc_pkg::SEG_HI[i]);
      else
        hit = (adc_code > tcc_pkg::SEG_LO[i]) && (adc_code <= tcc_pkg::SEG_HI[i]);
      if (!found && hit) begin
        found   = 1'b1;
        seg_sel = tcc_pkg::SEG_W'(i);
      end
    end
  end

  assign diff = adc_code - tcc_pkg::SEG_LO[seg_sel];

  always_comb begin
    item_next.inr   = found;
    item_next.seg   = seg_sel;
    item_next.delta = diff[tcc_pkg::DELTA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_item <= item_next;
    end
  end

endmodule

>>> rtl/core/tcc_queue.sv
// Short FIFO of classified beats between front and back.
// Uses tcc_pkg::item_t.
module tcc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output tcc_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcc_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/core/tcc_back.sv
// Back end: four-stage interpolation pipeline, slope * offset / span + base.
// Division is a reciprocal multiply with one correction step. Uses tcc_pkg tables.
module tcc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              avail,
  input  tcc_pkg::item_t                    item,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tcc_pkg::TEMP_W-1:0] temp_tenths,
  output logic                              in_range
);

  localparam int P_W = tcc_pkg::X_W + tcc_pkg::RECIP_W;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic                       s1_inr, s2_inr, s3_inr;
  logic [tcc_pkg::SEG_W-1:0]  s1_seg, s2_seg, s3_seg;
  logic [tcc_pkg::X_W-1:0]    s1_x, s2_x, s3_x;
  logic [tcc_pkg::QUOT_W-1:0] s2_q, s3_q;
  logic [tcc_pkg::X_W-1:0]    s3_prod;

  logic [P_W-1:0]             p;
  logic [tcc_pkg::X_W-1:0]    rem;
  logic [tcc_pkg::X_W-1:0]    span_x;
  logic                       fix;
  logic                       rem_nz;
  logic                       round_up;
  logic [tcc_pkg::QUOT_W-1:0] q_fin;
  logic signed [tcc_pkg::TEMP_W-1:0] temp_next;

  assign en4 = !v4 || !out_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = avail && en1;

  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= avail;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  assign p = P_W'(s1_x) * P_W'(tcc_pkg::SEG_RECIP[s1_seg]);

  // quotient estimate is low by at most one; the remainder test fixes it
  assign span_x = tcc_pkg::X_W'(tcc_pkg::SEG_SPAN[s3_seg]);
  assign rem    = s3_x - s3_prod;
  assign fix    = (rem >= span_x);
  assign rem_nz = fix ? (rem != span_x) : (rem != '0);
  // negative segments truncate toward zero, i.e. round the fraction up
  assign round_up = rem_nz && tcc_pkg::SEG_BASE[s3_seg][tcc_pkg::TEMP_W-1];
  assign q_fin = s3_q + tcc_pkg::QUOT_W'(fix) + tcc_pkg::QUOT_W'(round_up);
  assign temp_next = s3_inr
      ? tcc_pkg::SEG_BASE[s3_seg] + signed'(tcc_pkg::TEMP_W'(q_fin))
      : '0;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_inr <= item.inr;
      s1_seg <= item.seg;
      s1_x   <= tcc_pkg::X_W'(item.delta) * tcc_pkg::X_W'(tcc_pkg::SEG_SLOPE[item.seg]);
    end
    if (en2) begin
      s2_inr <= s1_inr;
      s2_seg <= s1_seg;
      s2_x   <= s1_x;
      s2_q   <= p[tcc_pkg::RECIP_SHIFT +: tcc_pkg::QUOT_W];
    end
    if (en3) begin
      s3_inr  <= s2_inr;
      s3_seg  <= s2_seg;
      s3_x    <= s2_x;
      s3_q    <= s2_q;
      s3_prod <= tcc_pkg::X_W'(s2_q) * tcc_pkg::X_W'(tcc_pkg::SEG_SPAN[s2_seg]);
    end
    if (en4) begin
      temp_tenths <= temp_next;
      in_range    <= s3_inr;
    end
  end

endmodule

>>> rtl/core/thermocouple_code_to_temperature.sv
// Type K thermocouple linearizer: signed ADC code in, temperature in 0.1 C out.
// Instantiates tcc_front, tcc_queue and tcc_back; uses tcc_pkg.
// Accepts one code per cycle while in_stall is low; each result passes through
// the classify register, which loads on the accepting edge, then the queue and
// the four interpolation stages. Codes at or below -148 or above 2642 return
// zero with in_range low. With the output stalled, an empty block takes
// QUEUE_DEPTH + 5 beats (front register, queue, four back stages) before it
// stalls the input.
module thermocouple_code_to_temperature #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tcc_pkg::CODE_W-1:0] adc_code,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tcc_pkg::TEMP_W-1:0] temp_tenths,
  output logic                              in_range
);

  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_nonempty;
  tcc_pkg::item_t push_item;
  tcc_pkg::item_t pop_item;

  tcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .adc_code   (adc_code),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  tcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .nonempty  (queue_nonempty),
    .pop_item  (pop_item)
  );

  tcc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (queue_nonempty),
    .item        (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temp_tenths (temp_tenths),
    .in_range    (in_range)
  );

endmodule

>>> tb/tb_thermocouple_code_to_temperature.sv
// Self-checking bench for thermocouple_code_to_temperature: directed codes at the
// segment edges and range limits, then random codes under changing backpressure.
// Depends on tcc_pkg and the RTL of thermocouple_code_to_temperature only.
module tb_thermocouple_code_to_temperature;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODE_W    = tcc_pkg::CODE_W;
  localparam int TEMP_W    = tcc_pkg::TEMP_W;
  localparam int SEG_COUNT = tcc_pkg::SEG_COUNT;

  localparam int ZERO_SEG    = 2;      // 0 to 5 C segment also takes its lower breakpoint
  localparam int PHASE_ITEMS = 667;
  localparam int DRAIN_CYC   = 16;

  // lower breakpoint, codes across, degrees at the breakpoint, degrees across
  localparam int BRK_LO [SEG_COUNT] = '{
    -148, -75, 0, 25, 51, 102, 154, 206, 259, 312, 418,
    524, 734, 940, 1144, 1352, 1563, 1778, 1991, 2207, 2424
  };
  localparam int BRK_SPAN [SEG_COUNT] = '{
    73, 75, 25, 26, 51, 52, 52, 53, 53, 106, 106,
    210, 206, 204, 208, 211, 215, 213, 216, 217, 218
  };
  localparam int BRK_T0 [SEG_COUNT] = '{
    -30, -15, 0, 5, 10, 20, 30, 40, 50, 60, 80,
    100, 140, 180, 220, 260, 300, 340, 380, 420, 460
  };
  localparam int BRK_DT [SEG_COUNT] = '{
    15, 15, 5, 5, 10, 10, 10, 10, 10, 20, 20,
    40, 40, 40, 40, 40, 40, 40, 40, 40, 40
  };

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     inr;
  } reading_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] code;
    logic                     typed;
    logic signed [TEMP_W-1:0] temp;
    logic                     inr;
  } code_row_t;

  localparam int N_ROWS = 19;
  localparam code_row_t DIRECTED_CODES [N_ROWS] = '{
    '{16'sh8000,   1'b1, 14'sd0,    1'b0},
    '{16'sh7FFF,   1'b1, 14'sd0,    1'b0},
    '{16'shAAAA,   1'b1, 14'sd0,    1'b0},
    '{16'sh5555,   1'b1, 14'sd0,    1'b0},
    '{-16'sd148,   1'b1, 14'sd0,    1'b0},
    '{-16'sd147,   1'b0, 14'sd0,    1'b0},
    '{-16'sd75,    1'b1, -14'sd150, 1'b1},
    '{-16'sd74,    1'b0, 14'sd0,    1'b0},
    '{-16'sd1,     1'b0, 14'sd0,    1'b0},
    '{16'sd0,      1'b1, 14'sd0,    1'b1},
    '{16'sd1,      1'b0, 14'sd0,    1'b0},
    '{16'sd25,     1'b1, 14'sd50,   1'b1},
    '{16'sd26,     1'b0, 14'sd0,    1'b0},
    '{16'sd940,    1'b1, 14'sd1800, 1'b1},
    '{16'sd941,    1'b0, 14'sd0,    1'b0},
    '{16'sd1144,   1'b1, 14'sd2200, 1'b1},
    '{16'sd1145,   1'b0, 14'sd0,    1'b0},
    '{16'sd2642,   1'b1, 14'sd5000, 1'b1},
    '{16'sd2643,   1'b1, 14'sd0,    1'b0}
  };

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic signed [CODE_W-1:0] adc_code  = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] temp_tenths;
  logic                     in_range;

  reading_t pending_temps[$];
  int       fail_count    = 0;
  int       send_idle_pct = 0;
  int       stall_pct     = 0;

  thermocouple_code_to_temperature u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .adc_code    (adc_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temp_tenths (temp_tenths),
    .in_range    (in_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[thermocouple_code_to_temperature] ERROR");
    $finish;
  end

  function automatic reading_t linearize(input logic signed [CODE_W-1:0] code);
    reading_t r;
    int       x;
    int       num;
    r.temp = '0;
    r.inr  = 1'b0;
    x      = code;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if ((x > BRK_LO[i] || (i == ZERO_SEG && x == BRK_LO[i])) &&
          x <= BRK_LO[i] + BRK_SPAN[i]) begin
        num    = 10 * BRK_T0[i] * BRK_SPAN[i] + 10 * BRK_DT[i] * (x - BRK_LO[i]);
        r.temp = TEMP_W'(num / BRK_SPAN[i]);  // truncates toward zero
        r.inr  = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic signed [CODE_W-1:0] pick_code();
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 55)
      return CODE_W'(int'($urandom_range(2789)) - 147);
    if (r < 78) begin
      k = $urandom_range(SEG_COUNT - 1);
      return CODE_W'(BRK_LO[k] + ($urandom_range(1) ? BRK_SPAN[k] : 0) +
                     int'($urandom_range(2)) - 1);
    end
    return CODE_W'($urandom());
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_code(input logic signed [CODE_W-1:0] code, input reading_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    adc_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_temps.push_back(want);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_temps.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_beat
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_temps.size() == 0) begin
        $error("unexpected beat: temp_tenths=%0d in_range=%0b", temp_tenths, in_range);
        fail_count++;
      end else begin
        want = pending_temps.pop_front();
        if (temp_tenths !== want.temp) begin
          $error("temp_tenths: expected %0d, got %0d", want.temp, temp_tenths);
          fail_count++;
        end
        if (in_range !== want.inr) begin
          $error("in_range: expected %0b, got %0b", want.inr, in_range);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    reading_t                 want;
    logic signed [CODE_W-1:0] code;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 17;
    stall_pct     = 78;
    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED_CODES[i].typed) begin
        want.temp = DIRECTED_CODES[i].temp;
        want.inr  = DIRECTED_CODES[i].inr;
      end else begin
        want = linearize(DIRECTED_CODES[i].code);
      end
      send_code(DIRECTED_CODES[i].code, want);
    end
    // hold the input off until everything in flight has come out
    drain();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 17 : (p == 1) ? 78 : 0;
      stall_pct     = (p == 0) ? 78 : (p == 1) ? 17 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        code = pick_code();
        send_code(code, linearize(code));
      end
      drain();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0)
      $display("[thermocouple_code_to_temperature] OK");
    else
      $display("[thermocouple_code_to_temperature] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/core/tcc_pkg.sv
rtl/core/tcc_front.sv
rtl/core/tcc_queue.sv
rtl/core/tcc_back.sv
rtl/core/thermocouple_code_to_temperature.sv
tb/tb_thermocouple_code_to_temperature.sv
